// ----- src/prime_and_twin_scanner_core_assert.svh -----
// Assertion macros for the prime and twin scanner.
`ifndef PRIME_AND_TWIN_SCANNER_CORE_ASSERT_SVH
`define PRIME_AND_TWIN_SCANNER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge out of reset.
`define PTWS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prime_and_twin_scanner_core: assertion failed");
// Next-cycle implication.
`define PTWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prime_and_twin_scanner_core: assertion failed");
`else
`define PTWS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PTWS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/ptws_pkg.sv -----
// Package with widths, microcode types and the microprogram of the scanner.
package ptws_pkg;

    // Width of candidates and of all kept values.
    localparam int VALUE_BITS = 16;
    // Width of the bit counter in the remainder unit.
    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

    typedef logic [VALUE_BITS-1:0] value_t;

    // Steps of the microprogram.
    typedef enum logic [3:0] {
        STEP_WAIT    = 4'd0,
        STEP_SMALL   = 4'd1,
        STEP_SQUARE  = 4'd2,
        STEP_COMPARE = 4'd3,
        STEP_DIVIDE  = 4'd4,
        STEP_TESTREM = 4'd5,
        STEP_LOOP    = 4'd6,
        STEP_REJECT  = 4'd7,
        STEP_FINISH  = 4'd8,
        STEP_RETURN  = 4'd9
    } step_t;

    // Datapath operations; an operation runs only when its step does not jump.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQUARE,
        OP_DIV_START,
        OP_NEXT_DIV,
        OP_REJECT,
        OP_FINISH
    } op_t;

    // Jump conditions.
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_SMALL,
        COND_SQ_GT,
        COND_DIV_BUSY,
        COND_REM_ZERO,
        COND_OUT_BUSY
    } cond_t;

    // One control word of the microprogram.
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ucode_word_t;

    // Control and status between the sequencer and the remainder unit.
    typedef struct packed {
        logic start;
    } rem_ctrl_t;

    typedef struct packed {
        logic busy;
    } rem_stat_t;

    // Microprogram ROM.
    function automatic ucode_word_t ucode(input step_t pc);
        ucode_word_t w;
        unique case (pc)
            STEP_WAIT:    w = '{OP_LOAD,      COND_NO_INPUT, STEP_WAIT};
            STEP_SMALL:   w = '{OP_NONE,      COND_SMALL,    STEP_REJECT};
            STEP_SQUARE:  w = '{OP_SQUARE,    COND_NEVER,    STEP_WAIT};
            STEP_COMPARE: w = '{OP_DIV_START, COND_SQ_GT,    STEP_FINISH};
            STEP_DIVIDE:  w = '{OP_NONE,      COND_DIV_BUSY, STEP_DIVIDE};
            STEP_TESTREM: w = '{OP_NEXT_DIV,  COND_REM_ZERO, STEP_REJECT};
            STEP_LOOP:    w = '{OP_NONE,      COND_ALWAYS,   STEP_SQUARE};
            STEP_REJECT:  w = '{OP_REJECT,    COND_NEVER,    STEP_WAIT};
            STEP_FINISH:  w = '{OP_FINISH,    COND_OUT_BUSY, STEP_FINISH};
            STEP_RETURN:  w = '{OP_NONE,      COND_ALWAYS,   STEP_WAIT};
            default:      w = '{OP_NONE,      COND_ALWAYS,   STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ----- src/prime_and_twin_scanner_core.sv -----
// Top level of the prime and twin scanner: microcoded sequencer and datapath.
// Usage:
// The host sends candidates on the input channel (in_valid, in_ready, candidate,
// restart), normally in descending order down to 2; restart set on the first one
// clears the last prime and the prime count before that candidate is tested.
// Each candidate yields one transaction on the output channel (out_valid,
// out_ready, tested_value, is_prime, is_twin, twin_upper, prime_count).
// One candidate is in work at a time; in_ready is high only while the
// sequencer waits at its first step. Trial divisors run from 2 while d*d <= n.
// Each trial divisor is tested by the bit-serial remainder unit; 0 and 1 are
// rejected at once, and 2 and 3 finish without any division.
// A finished result sits in the output register; the next candidate is taken
// while it waits, and the sequencer only stalls at its final step if the
// previous result has still not been taken.
// Reset clears the sequencer, the output valid, the last prime and the count.
`include "prime_and_twin_scanner_core_assert.svh"

module prime_and_twin_scanner_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  ptws_pkg::value_t        candidate,
    input  logic                    restart,
    output logic                    out_valid,
    input  logic                    out_ready,
    output ptws_pkg::value_t        tested_value,
    output logic                    is_prime,
    output logic                    is_twin,
    output ptws_pkg::value_t        twin_upper,
    output ptws_pkg::value_t        prime_count
);

    localparam int W = ptws_pkg::VALUE_BITS;

    ptws_pkg::step_t       pc_reg;
    ptws_pkg::step_t       pc_next;
    ptws_pkg::ucode_word_t word;
    logic                  jump;
    logic                  exec;

    ptws_pkg::value_t      n_reg;
    ptws_pkg::value_t      n_next;
    ptws_pkg::value_t      d_reg;
    ptws_pkg::value_t      d_next;
    logic [2*W-1:0]        sq_reg;
    logic [2*W-1:0]        sq_next;
    logic                  prime_reg;
    logic                  prime_next;
    ptws_pkg::value_t      prev_reg;
    ptws_pkg::value_t      prev_next;
    ptws_pkg::value_t      count_reg;
    ptws_pkg::value_t      count_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    ptws_pkg::value_t      out_value_reg;
    ptws_pkg::value_t      out_value_next;
    logic                  out_prime_reg;
    logic                  out_prime_next;
    logic                  out_twin_reg;
    logic                  out_twin_next;
    ptws_pkg::value_t      out_upper_reg;
    ptws_pkg::value_t      out_upper_next;
    ptws_pkg::value_t      out_count_reg;
    ptws_pkg::value_t      out_count_next;

    ptws_pkg::rem_ctrl_t   rem_ctrl;
    ptws_pkg::rem_stat_t   rem_stat;
    ptws_pkg::value_t      rem_value;

    logic                  twin;
    ptws_pkg::value_t      count_inc;
    logic                  twin_gap_ok;

    // Remainder unit.
    ptws_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (rem_ctrl),
        .dividend  (n_reg),
        .divisor   (d_reg),
        .stat      (rem_stat),
        .remainder (rem_value)
    );

    // Fetch the control word and evaluate its jump condition.
    always_comb
    begin
        word = ptws_pkg::ucode(pc_reg);
        unique case (word.cond)
            ptws_pkg::COND_NEVER:    jump = 1'b0;
            ptws_pkg::COND_ALWAYS:   jump = 1'b1;
            ptws_pkg::COND_NO_INPUT: jump = !in_valid;
            ptws_pkg::COND_SMALL:    jump = (n_reg < W'(2));
            ptws_pkg::COND_SQ_GT:    jump = (sq_reg > {{W{1'b0}}, n_reg});
            ptws_pkg::COND_DIV_BUSY: jump = rem_stat.busy;
            ptws_pkg::COND_REM_ZERO: jump = (rem_value == '0);
            ptws_pkg::COND_OUT_BUSY: jump = out_valid_reg && !out_ready;
            default:                 jump = 1'b1;
        endcase
        exec = !jump;
    end

    // Next step of the sequencer.
    always_comb
    begin
        if (jump)
        begin
            pc_next = word.target;
        end
        else
        begin
            pc_next = ptws_pkg::step_t'(pc_reg + 4'd1);
        end
    end

    // Twin test and saturating count for the finishing step.
    always_comb
    begin
        twin = prime_reg && ({1'b0, prev_reg} == ({1'b0, n_reg} + (W+1)'(2)));
        if (count_reg != '1)
        begin
            count_inc = count_reg + W'(1);
        end
        else
        begin
            count_inc = count_reg;
        end
    end

    // Datapath controls decoded from the operation field.
    always_comb
    begin
        n_next         = n_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        prime_next     = prime_reg;
        prev_next      = prev_reg;
        count_next     = count_reg;
        rem_ctrl.start = 1'b0;
        out_value_next = out_value_reg;
        out_prime_next = out_prime_reg;
        out_twin_next  = out_twin_reg;
        out_upper_next = out_upper_reg;
        out_count_next = out_count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (exec)
        begin
            unique case (word.op)
                ptws_pkg::OP_NONE:
                begin
                end
                ptws_pkg::OP_LOAD:
                begin
                    n_next     = candidate;
                    d_next     = W'(2);
                    prime_next = 1'b1;
                    if (restart)
                    begin
                        prev_next  = '0;
                        count_next = '0;
                    end
                end
                ptws_pkg::OP_SQUARE:
                begin
                    sq_next = d_reg * d_reg;
                end
                ptws_pkg::OP_DIV_START:
                begin
                    rem_ctrl.start = 1'b1;
                end
                ptws_pkg::OP_NEXT_DIV:
                begin
                    d_next = d_reg + W'(1);
                end
                ptws_pkg::OP_REJECT:
                begin
                    prime_next = 1'b0;
                end
                ptws_pkg::OP_FINISH:
                begin
                    out_valid_next = 1'b1;
                    out_value_next = n_reg;
                    out_prime_next = prime_reg;
                    out_twin_next  = twin;
                    out_upper_next = twin ? prev_reg : '0;
                    if (prime_reg)
                    begin
                        prev_next      = n_reg;
                        count_next     = count_inc;
                        out_count_next = count_inc;
                    end
                    else
                    begin
                        out_count_next = count_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control state and kept state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= ptws_pkg::STEP_WAIT;
            out_valid_reg <= 1'b0;
            prev_reg      <= '0;
            count_reg     <= '0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            prev_reg      <= prev_next;
            count_reg     <= count_next;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        d_reg         <= d_next;
        sq_reg        <= sq_next;
        prime_reg     <= prime_next;
        out_value_reg <= out_value_next;
        out_prime_reg <= out_prime_next;
        out_twin_reg  <= out_twin_next;
        out_upper_reg <= out_upper_next;
        out_count_reg <= out_count_next;
    end

    assign in_ready     = (pc_reg == ptws_pkg::STEP_WAIT);
    assign out_valid    = out_valid_reg;
    assign tested_value = out_value_reg;
    assign is_prime     = out_prime_reg;
    assign is_twin      = out_twin_reg;
    assign twin_upper   = out_upper_reg;
    assign prime_count  = out_count_reg;

    // The reported upper member lies two above the tested value, compared without wraparound.
    assign twin_gap_ok = ({1'b0, twin_upper} == ({1'b0, tested_value} + (W+1)'(2)));

    // The remainder unit is idle whenever a new candidate can be taken.
    `PTWS_ASSERT_IMPL(a_idle_rem, clk, rst_n, in_ready, !rem_stat.busy)
    // An accepted candidate moves the sequencer off the waiting step.
    `PTWS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    // A twin is always prime and its upper member is two above the tested value.
    `PTWS_ASSERT_IMPL(a_twin_prime, clk, rst_n, out_valid && is_twin, is_prime && twin_gap_ok)
    // A non-twin result reports zero as the upper member.
    `PTWS_ASSERT_IMPL(a_twin_zero, clk, rst_n, out_valid && !is_twin, twin_upper == '0)

endmodule

// ----- src/ptws_rem.sv -----
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module ptws_rem (
    input  logic                clk,
    input  logic                rst_n,
    input  ptws_pkg::rem_ctrl_t ctrl,
    input  ptws_pkg::value_t    dividend,
    input  ptws_pkg::value_t    divisor,
    output ptws_pkg::rem_stat_t stat,
    output ptws_pkg::value_t    remainder
);

    logic                          busy_reg;
    logic                          busy_next;
    logic [ptws_pkg::CNT_BITS-1:0] cnt_reg;
    logic [ptws_pkg::CNT_BITS-1:0] cnt_next;
    ptws_pkg::value_t              shift_reg;
    ptws_pkg::value_t              shift_next;
    ptws_pkg::value_t              divisor_reg;
    ptws_pkg::value_t              divisor_next;
    ptws_pkg::value_t              rem_reg;
    ptws_pkg::value_t              rem_next;
    logic [ptws_pkg::VALUE_BITS:0] trial;
    ptws_pkg::value_t              diff;

    // Shift in the next dividend bit and subtract the divisor when it fits.
    // The partial remainder stays below the divisor, so the difference fits the value width.
    always_comb
    begin
        trial        = {rem_reg, shift_reg[ptws_pkg::VALUE_BITS-1]};
        diff         = trial[ptws_pkg::VALUE_BITS-1:0] - divisor_reg;
        busy_next    = busy_reg;
        cnt_next     = cnt_reg;
        shift_next   = shift_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        if (ctrl.start)
        begin
            busy_next    = 1'b1;
            cnt_next     = ptws_pkg::CNT_BITS'(ptws_pkg::VALUE_BITS);
            shift_next   = dividend;
            divisor_next = divisor;
            rem_next     = '0;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[ptws_pkg::VALUE_BITS-2:0], 1'b0};
            if (trial >= {1'b0, divisor_reg})
            begin
                rem_next = diff;
            end
            else
            begin
                rem_next = trial[ptws_pkg::VALUE_BITS-1:0];
            end
            cnt_next = cnt_reg - ptws_pkg::CNT_BITS'(1);
            if (cnt_reg == ptws_pkg::CNT_BITS'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        shift_reg   <= shift_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign remainder = rem_reg;

endmodule
